### rtl/ptts_pkg.sv
// Shared types and codes for the periodic task tick scheduler.
// Holds request and status codes, the slot entry layout and the sequencer states.
// No dependencies.
`default_nettype none

package ptts_pkg;

	localparam logic [1:0] REQ_REGISTER   = 2'd0;
	localparam logic [1:0] REQ_UNREGISTER = 2'd1;
	localparam logic [1:0] REQ_TICK       = 2'd2;

	localparam logic [1:0] STAT_OK          = 2'd0;
	localparam logic [1:0] STAT_BOUNDS      = 2'd1;
	localparam logic [1:0] STAT_ZERO_PERIOD = 2'd2;
	localparam logic [1:0] STAT_BUSY        = 2'd3;

	typedef struct packed {
		logic [15:0] period;
		logic [15:0] countdown;
		logic [15:0] total;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_FIN  = 3'b100
	} state_t;

endpackage

`default_nettype wire

### rtl/ptts_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
`default_nettype none

module ptts_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                      wr_data,
	input  wire logic                                  rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/periodic_task_tick_scheduler.sv
// Periodic task tick scheduler: slot table in one RAM, enable bits in flops.
// Depends on ptts_pkg and ptts_ram.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  in      | in_valid/in_ready  | req_type, task_index, phase_delay, period_ticks
//  out     | out_valid/out_ready| status, fired, fired_slot, activation_total, last
//
// Register, unregister and unused requests load their result word into the output
// register at acceptance.
// A tick walks the slots through one RAM read port, one slot per cycle while the
// output keeps up, read and write-back pipelined.
// A fired word is held until another slot fires so the final word can carry last.
// Reset clears the enable bits and control; the RAM needs no clearing pass.
// A full output register stalls the walk on a second firing slot.
`default_nettype none

module periodic_task_tick_scheduler #(
	parameter int NUM_SLOTS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [3:0]  task_index,
	input  wire logic [15:0] phase_delay,
	input  wire logic [15:0] period_ticks,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             fired,
	output logic [3:0]       fired_slot,
	output logic [15:0]      activation_total,
	output logic             last
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	ptts_pkg::state_t st_q;

	logic [NUM_SLOTS-1:0] en_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic                 issue_q;
	logic                 valid_s1;
	logic [IDX_W-1:0]     idx_s1;

	logic                 pend_valid_q;
	logic [3:0]           pend_slot_q;
	logic [15:0]          pend_total_q;

	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic                 fired_q;
	logic [3:0]           fired_slot_q;
	logic [15:0]          total_q;
	logic                 last_q;

	logic                          ram_wr_en;
	logic [IDX_W-1:0]              ram_wr_addr;
	ptts_pkg::entry_t              ram_wr_entry;
	logic                          ram_rd_en;
	logic [ptts_pkg::ENTRY_W-1:0]  ram_rd_data;
	ptts_pkg::entry_t              ent_s1;

	logic       out_free;
	logic       accept;
	logic       in_range;
	logic       reg_ok;
	logic [1:0] reg_status;
	logic       hit_s1;
	logic       fire_s1;
	logic       stall;
	logic       go;

	logic        out_load;
	logic [1:0]  ld_status;
	logic        ld_fired;
	logic [3:0]  ld_slot;
	logic [15:0] ld_total;
	logic        ld_last;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (st_q == ptts_pkg::S_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign in_range = ({1'b0, task_index} < 5'(NUM_SLOTS));

	always_comb begin
		reg_status = ptts_pkg::STAT_OK;
		if (!in_range) begin
			reg_status = ptts_pkg::STAT_BOUNDS;
		end else if (period_ticks == 16'd0) begin
			reg_status = ptts_pkg::STAT_ZERO_PERIOD;
		end else if (en_q[task_index[IDX_W-1:0]]) begin
			reg_status = ptts_pkg::STAT_BUSY;
		end
	end

	assign reg_ok = accept && (req_type == ptts_pkg::REQ_REGISTER)
		&& (reg_status == ptts_pkg::STAT_OK);

	assign ent_s1  = ptts_pkg::entry_t'(ram_rd_data);
	assign hit_s1  = (st_q == ptts_pkg::S_WALK) && valid_s1 && en_q[idx_s1];
	assign fire_s1 = hit_s1 && (ent_s1.countdown == 16'd0);
	assign stall   = fire_s1 && pend_valid_q && !out_free;
	assign go      = !stall;

	always_comb begin
		ram_wr_en    = 1'b0;
		ram_wr_addr  = idx_s1;
		ram_wr_entry = ent_s1;
		if (reg_ok) begin
			ram_wr_en              = 1'b1;
			ram_wr_addr            = task_index[IDX_W-1:0];
			ram_wr_entry.period    = period_ticks;
			ram_wr_entry.countdown = phase_delay;
			ram_wr_entry.total     = 16'd0;
		end else if (hit_s1 && go) begin
			ram_wr_en = 1'b1;
			if (fire_s1) begin
				ram_wr_entry.countdown = ent_s1.period - 16'd1;
				ram_wr_entry.total     = ent_s1.total + 16'd1;
			end else begin
				ram_wr_entry.countdown = ent_s1.countdown - 16'd1;
			end
		end
	end

	assign ram_rd_en = (st_q == ptts_pkg::S_WALK) && issue_q && go;

	ptts_ram #(
		.WIDTH (ptts_pkg::ENTRY_W),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_entry),
		.rd_en   (ram_rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (ram_rd_data)
	);

	always_comb begin
		out_load  = 1'b0;
		ld_status = ptts_pkg::STAT_OK;
		ld_fired  = 1'b0;
		ld_slot   = 4'd0;
		ld_total  = 16'd0;
		ld_last   = 1'b1;
		case (st_q)
			ptts_pkg::S_IDLE: begin
				if (accept) begin
					case (req_type)
						ptts_pkg::REQ_REGISTER: begin
							out_load  = 1'b1;
							ld_status = reg_status;
						end
						ptts_pkg::REQ_UNREGISTER: begin
							out_load  = 1'b1;
							ld_status = in_range ? ptts_pkg::STAT_OK : ptts_pkg::STAT_BOUNDS;
						end
						ptts_pkg::REQ_TICK: begin
							out_load = 1'b0;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			ptts_pkg::S_WALK: begin
				if (fire_s1 && pend_valid_q && out_free) begin
					out_load = 1'b1;
					ld_fired = 1'b1;
					ld_slot  = pend_slot_q;
					ld_total = pend_total_q;
					ld_last  = 1'b0;
				end
			end
			ptts_pkg::S_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					ld_fired = pend_valid_q;
					ld_slot  = pend_valid_q ? pend_slot_q : 4'd0;
					ld_total = pend_valid_q ? pend_total_q : 16'd0;
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ptts_pkg::S_IDLE;
			en_q         <= '0;
			rd_idx_q     <= '0;
			issue_q      <= 1'b0;
			valid_s1     <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ptts_pkg::S_IDLE: begin
					if (reg_ok) begin
						en_q[task_index[IDX_W-1:0]] <= 1'b1;
					end
					if (accept && (req_type == ptts_pkg::REQ_UNREGISTER) && in_range) begin
						en_q[task_index[IDX_W-1:0]] <= 1'b0;
					end
					if (accept && (req_type == ptts_pkg::REQ_TICK)) begin
						st_q         <= ptts_pkg::S_WALK;
						rd_idx_q     <= IDX_W'(NUM_SLOTS - 1);
						issue_q      <= 1'b1;
						valid_s1     <= 1'b0;
						pend_valid_q <= 1'b0;
					end
				end
				ptts_pkg::S_WALK: begin
					if (go) begin
						valid_s1 <= issue_q;
						if (issue_q) begin
							if (rd_idx_q == '0) begin
								issue_q <= 1'b0;
							end else begin
								rd_idx_q <= rd_idx_q - 1'b1;
							end
						end else begin
							st_q <= ptts_pkg::S_FIN;
						end
						if (fire_s1) begin
							pend_valid_q <= 1'b1;
						end
					end
				end
				ptts_pkg::S_FIN: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						st_q         <= ptts_pkg::S_IDLE;
					end
				end
				default: begin
					st_q <= ptts_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ram_rd_en) begin
			idx_s1 <= rd_idx_q;
		end
		if (fire_s1 && go) begin
			pend_slot_q  <= 4'(idx_s1);
			pend_total_q <= ent_s1.total + 16'd1;
		end
		if (out_load) begin
			status_q     <= ld_status;
			fired_q      <= ld_fired;
			fired_slot_q <= ld_slot;
			total_q      <= ld_total;
			last_q       <= ld_last;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign fired            = fired_q;
	assign fired_slot       = fired_slot_q;
	assign activation_total = total_q;
	assign last             = last_q;

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ptts_pkg::S_IDLE) |-> !pend_valid_q)
		else $error("pending fired word left in idle");

	a_walk_write_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_wr_en && (st_q == ptts_pkg::S_WALK)) |-> en_q[idx_s1])
		else $error("walk wrote back a disabled slot");

	a_walk_word_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (st_q == ptts_pkg::S_WALK)) |=> (!last_q && fired_q))
		else $error("mid-walk word marked last or not fired");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> (valid_s1 && $stable(idx_s1) && $stable(ram_rd_data)))
		else $error("stalled slot stage changed");

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> ((st_q == ptts_pkg::S_IDLE) && !valid_s1 && !issue_q))
		else $error("input ready during a walk");

endmodule

`default_nettype wire
